@@ sv/ffa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the first-fit arena allocator.
// No dependencies.
package ffa_pkg;

  typedef logic [1:0] ffa_status_t;

  localparam ffa_status_t ST_OK        = 2'd0;
  localparam ffa_status_t ST_NO_FIT    = 2'd1;
  localparam ffa_status_t ST_NOT_ALLOC = 2'd2;
  localparam ffa_status_t ST_FULL      = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [31:0] ARENA_RESET = 32'd65536;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_BLK_SCAN,
    S_BLK_CHK,
    S_SEG_RD,
    S_SEG_CHK,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SEG_WR,
    S_FIN
  } ffa_state_t;

endpackage

@@ sv/ffa_req_if.sv @@
`timescale 1ns / 1ps
// Request channel: valid/ready plus one request word.
// Depends on nothing.
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] alloc_size;
  logic [4:0]  align_log2;
  logic [31:0] address;

  modport source (output valid, action, alloc_size, align_log2, address, input ready);
  modport sink   (input valid, action, alloc_size, align_log2, address, output ready);
endinterface

@@ sv/ffa_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel: valid/ready plus one result word.
// Depends on nothing.
interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_address;
  logic [31:0] block_length;
  logic [31:0] used_total;

  modport source (output valid, status, result_address, block_length, used_total,
                  input ready);
  modport sink   (input valid, status, result_address, block_length, used_total,
                  output ready);
endinterface

@@ sv/first_fit_arena_allocator.sv @@
`timescale 1ns / 1ps
// First-fit arena allocator: top level.
// Depends on ffa_pkg, ffa_req_if, ffa_rsp_if.
//
// Usage:
//   in_chan carries one request word per handshake: allocate (size, alignment)
//   or free (aligned address). out_chan returns one result word per request:
//   status, granted address, block length with padding, bytes in use after.
//   cfg_we/cfg_wdata write the arena size; the write rebuilds the free list to
//   a single segment and empties the allocation table. Write it only when idle.
// Timing:
//   One request at a time. The allocation table (block memory) is walked one
//   entry per cycle for allocate (valid bits) and entry by entry for free
//   (read, then compare). The free-segment memory is then walked segment by
//   segment (read, then check); removing or inserting a segment moves the tail
//   of the list entry by entry (read, then write).
// Reset:
//   Synchronous, active low. After reset the segment memory entry 0 is written
//   with the default arena, then in_chan.ready rises.
// Stall:
//   The result sits in an output register; if the receiver stalls, the block
//   holds the next finished result and accepts no new word until it drains.
module first_fit_arena_allocator #(
  parameter int FREE_SEGMENTS = 16,
  parameter int ALLOC_ENTRIES = 32,
  parameter int ADDR_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  ffa_req_if.sink     in_chan,
  ffa_rsp_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import ffa_pkg::*;

  localparam int AB  = ADDR_BITS;
  localparam int WW  = ((AB > 32) ? AB : 32) + 1;   // room for sums and carries
  localparam int SIW = (FREE_SEGMENTS > 1) ? $clog2(FREE_SEGMENTS) : 1;
  localparam int SCW = $clog2(FREE_SEGMENTS + 1);
  localparam int BIW = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;
  localparam int BCW = $clog2(ALLOC_ENTRIES + 1);

  typedef struct packed {
    logic [AB-1:0] base;
    logic [AB-1:0] len;
  } seg_t;

  typedef struct packed {
    logic [AB-1:0] addr;
    logic [AB-1:0] len;
    logic [AB-1:0] pad;
  } blk_t;

  function automatic logic [WW-1:0] ext_a(input logic [AB-1:0] v);
    return {{(WW-AB){1'b0}}, v};
  endfunction

  function automatic logic [WW-1:0] ext_w(input logic [31:0] v);
    return {{(WW-32){1'b0}}, v};
  endfunction

  // Arena is clamped to 2^AB - 1 bytes.
  function automatic logic [AB-1:0] clamp_f(input logic [31:0] v);
    logic [WW-1:0] e;
    logic [WW-1:0] m;
    logic [WW-1:0] c;
    e = ext_w(v);
    m = (WW'(1) << AB) - WW'(1);
    c = (e > m) ? m : e;
    return c[AB-1:0];
  endfunction

  // ---------------- memories ----------------
  seg_t seg_mem [FREE_SEGMENTS];
  blk_t blk_mem [ALLOC_ENTRIES];

  logic           seg_we;
  logic [SIW-1:0] seg_waddr;
  seg_t           seg_wdata;
  logic [SIW-1:0] seg_raddr;
  seg_t           seg_rd_q;

  logic           blk_we;
  logic [BIW-1:0] blk_waddr;
  blk_t           blk_wdata;
  blk_t           blk_rd_q;

  // ---------------- state ----------------
  ffa_state_t         state_r, state_nxt;
  logic [SCW-1:0]     seg_cnt_r;
  logic [31:0]        used_r;
  logic [ALLOC_ENTRIES-1:0] valid_r;
  logic               out_valid_r;

  logic               act_r;
  logic [31:0]        size_r;
  logic [4:0]         alog_r;
  logic [AB-1:0]      faddr_r;
  logic [BCW-1:0]     bidx_r;
  logic [BIW-1:0]     slot_r;
  logic [SCW-1:0]     sidx_r;
  logic [AB-1:0]      blen_r;
  logic [AB-1:0]      real_r;
  seg_t               prev_r, next_r;
  logic               has_prev_r, has_next_r;
  logic               pw_en_r;
  logic [SIW-1:0]     pw_idx_r;
  seg_t               pw_data_r;
  logic               sh_up_r;
  logic [SCW-1:0]     sh_j_r, sh_lim_r;
  ffa_status_t        res_status_r;
  logic [31:0]        res_addr_r, res_len_r;
  ffa_status_t        out_status_r;
  logic [31:0]        out_addr_r, out_len_r, out_used_r;

  // ---------------- decode ----------------
  logic           accept;
  logic           fin_go;
  logic [BIW-1:0] bidx_ix;
  logic           bidx_in;
  logic [SIW-1:0] sidx_ix;
  logic           sidx_in;
  logic           blk_hit;
  logic [WW-1:0]  in_addr_w;
  logic [WW-1:0]  blen_w;

  assign accept    = in_chan.valid && in_chan.ready;
  assign fin_go    = !out_valid_r || out_chan.ready;
  assign bidx_ix   = bidx_r[BIW-1:0];
  assign bidx_in   = bidx_r < BCW'(ALLOC_ENTRIES);
  assign sidx_ix   = sidx_r[SIW-1:0];
  assign sidx_in   = sidx_r < seg_cnt_r;
  assign blk_hit   = valid_r[bidx_ix] && (blk_rd_q.addr == faddr_r);
  assign in_addr_w = ext_w(in_chan.address);
  assign blen_w    = ext_a(blen_r);

  // allocate fit test on the segment just read
  logic [WW-1:0] a_base, a_len, a_align, a_rem, a_pad, a_total, a_size;
  logic [WW-1:0] a_newbase, a_newlen, a_aligned;
  logic          a_fit, a_empty;

  always_comb begin
    a_base    = ext_a(seg_rd_q.base);
    a_len     = ext_a(seg_rd_q.len);
    a_size    = ext_w(size_r);
    a_align   = WW'(1) << alog_r;
    a_rem     = a_base & (a_align - WW'(1));
    a_pad     = (a_rem != '0) ? (a_align - a_rem) : '0;
    a_fit     = (a_pad <= a_len) && (a_size <= (a_len - a_pad));
    a_total   = a_size + a_pad;
    a_newbase = a_base + a_total;
    a_newlen  = a_len - a_total;
    a_empty   = (a_newlen == '0);
    a_aligned = a_base + a_pad;
  end

  // free: neighbor merge decisions
  logic [AB-1:0] p_newlen;
  logic          merge_p, merge_pn, merge_n, ins_full, seg_lt;

  always_comb begin
    p_newlen = prev_r.len + blen_r;
    merge_p  = has_prev_r && (ext_a(prev_r.base) + ext_a(prev_r.len) == ext_a(real_r));
    merge_pn = merge_p && has_next_r
               && (ext_a(prev_r.base) + ext_a(p_newlen) == ext_a(next_r.base));
    merge_n  = !merge_p && has_next_r
               && (ext_a(next_r.base) == ext_a(real_r) + ext_a(blen_r));
    ins_full = !merge_p && !merge_n && (seg_cnt_r >= SCW'(FREE_SEGMENTS));
    seg_lt   = seg_rd_q.base < real_r;
  end

  logic sh_more;
  logic [SCW-1:0] sh_src;
  assign sh_more = sh_up_r ? (sh_j_r > sh_lim_r) : (sh_j_r < sh_lim_r);
  assign sh_src  = sh_up_r ? (sh_j_r - SCW'(1)) : (sh_j_r + SCW'(1));

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:     state_nxt = S_IDLE;
      S_IDLE:     if (accept) state_nxt = S_BLK_SCAN;
      S_BLK_SCAN: begin
        if (!bidx_in) state_nxt = S_FIN;
        else if (act_r == ACT_FREE) state_nxt = S_BLK_CHK;
        else if (!valid_r[bidx_ix]) state_nxt = S_SEG_RD;
      end
      S_BLK_CHK: begin
        if (!blk_hit) state_nxt = S_BLK_SCAN;
        else if (blk_rd_q.len == '0) state_nxt = S_FIN;
        else state_nxt = S_SEG_RD;
      end
      S_SEG_RD: begin
        if (sidx_in) state_nxt = S_SEG_CHK;
        else if (act_r == ACT_FREE) state_nxt = S_DECIDE;
        else state_nxt = S_FIN;
      end
      S_SEG_CHK: begin
        if (act_r == ACT_ALLOC) state_nxt = a_fit ? S_SHIFT_RD : S_SEG_RD;
        else state_nxt = seg_lt ? S_SEG_RD : S_DECIDE;
      end
      S_DECIDE:   state_nxt = ins_full ? S_FIN : S_SHIFT_RD;
      S_SHIFT_RD: begin
        if (sh_more) state_nxt = S_SHIFT_WR;
        else state_nxt = pw_en_r ? S_SEG_WR : S_FIN;
      end
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_SEG_WR:   state_nxt = S_FIN;
      S_FIN:      if (fin_go) state_nxt = S_IDLE;
      default:    state_nxt = S_INIT;
    endcase
  end

  // ---------------- memory controls ----------------
  always_comb begin
    seg_we    = 1'b0;
    seg_waddr = '0;
    seg_wdata = '0;
    seg_raddr = sidx_ix;
    blk_we    = 1'b0;
    blk_waddr = slot_r;
    blk_wdata = '{addr: a_aligned[AB-1:0], len: a_total[AB-1:0], pad: a_pad[AB-1:0]};
    if (state_r == S_SHIFT_RD) seg_raddr = sh_src[SIW-1:0];
    priority if (cfg_we) begin
      seg_we    = 1'b1;
      seg_wdata = '{base: '0, len: clamp_f(cfg_wdata)};
    end else if (state_r == S_INIT) begin
      seg_we    = 1'b1;
      seg_wdata = '{base: '0, len: clamp_f(ARENA_RESET)};
    end else if (state_r == S_SHIFT_WR) begin
      seg_we    = 1'b1;
      seg_waddr = sh_j_r[SIW-1:0];
      seg_wdata = seg_rd_q;
    end else if (state_r == S_SEG_WR) begin
      seg_we    = 1'b1;
      seg_waddr = pw_idx_r;
      seg_wdata = pw_data_r;
    end else begin
      seg_we = 1'b0;
    end
    if (state_r == S_SEG_CHK && act_r == ACT_ALLOC && a_fit) blk_we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (seg_we) seg_mem[seg_waddr] <= seg_wdata;
    seg_rd_q <= seg_mem[seg_raddr];
  end

  always_ff @(posedge clk) begin
    if (blk_we) blk_mem[blk_waddr] <= blk_wdata;
    blk_rd_q <= blk_mem[bidx_ix];
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      seg_cnt_r   <= SCW'(1);
      used_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && fin_go) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        seg_cnt_r <= (clamp_f(cfg_wdata) != '0) ? SCW'(1) : SCW'(0);
        used_r    <= '0;
        valid_r   <= '0;
      end else begin
        case (state_r)
          S_BLK_CHK: if (blk_hit && blk_rd_q.len == '0) valid_r[bidx_ix] <= 1'b0;
          S_SEG_CHK: begin
            if (act_r == ACT_ALLOC && a_fit) begin
              valid_r[slot_r] <= 1'b1;
              used_r          <= used_r + a_total[31:0];
              if (a_empty) seg_cnt_r <= seg_cnt_r - SCW'(1);
            end
          end
          S_DECIDE: begin
            if (!ins_full) begin
              valid_r[slot_r] <= 1'b0;
              used_r          <= used_r - blen_w[31:0];
              if (merge_pn) seg_cnt_r <= seg_cnt_r - SCW'(1);
              else if (!merge_p && !merge_n) seg_cnt_r <= seg_cnt_r + SCW'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // ---------------- request datapath ----------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_r      <= in_chan.action;
          size_r     <= in_chan.alloc_size;
          alog_r     <= in_chan.align_log2;
          faddr_r    <= in_addr_w[AB-1:0];
          bidx_r     <= '0;
          sidx_r     <= '0;
          has_prev_r <= 1'b0;
          has_next_r <= 1'b0;
          pw_en_r    <= 1'b0;
          sh_up_r    <= 1'b0;
          sh_j_r     <= '0;
          sh_lim_r   <= '0;
        end
      end
      S_BLK_SCAN: begin
        if (!bidx_in) begin
          res_status_r <= (act_r == ACT_ALLOC) ? ST_FULL : ST_NOT_ALLOC;
          res_addr_r   <= '0;
          res_len_r    <= '0;
        end else if (act_r == ACT_ALLOC) begin
          if (!valid_r[bidx_ix]) slot_r <= bidx_ix;
          else bidx_r <= bidx_r + BCW'(1);
        end
      end
      S_BLK_CHK: begin
        if (blk_hit) begin
          slot_r       <= bidx_ix;
          blen_r       <= blk_rd_q.len;
          real_r       <= faddr_r - blk_rd_q.pad;
          res_status_r <= ST_OK;
          res_addr_r   <= '0;
          res_len_r    <= '0;
        end else begin
          bidx_r <= bidx_r + BCW'(1);
        end
      end
      S_SEG_RD: begin
        if (!sidx_in && act_r == ACT_ALLOC) begin
          res_status_r <= ST_NO_FIT;
          res_addr_r   <= '0;
          res_len_r    <= '0;
        end
      end
      S_SEG_CHK: begin
        if (act_r == ACT_ALLOC) begin
          if (a_fit) begin
            res_status_r <= ST_OK;
            res_addr_r   <= a_aligned[31:0];
            res_len_r    <= a_total[31:0];
            pw_en_r      <= !a_empty;
            pw_idx_r     <= sidx_ix;
            pw_data_r    <= '{base: a_newbase[AB-1:0], len: a_newlen[AB-1:0]};
            if (a_empty) begin
              sh_j_r   <= sidx_r;
              sh_lim_r <= seg_cnt_r - SCW'(1);
            end
          end else begin
            sidx_r <= sidx_r + SCW'(1);
          end
        end else if (seg_lt) begin
          prev_r     <= seg_rd_q;
          has_prev_r <= 1'b1;
          sidx_r     <= sidx_r + SCW'(1);
        end else begin
          next_r     <= seg_rd_q;
          has_next_r <= 1'b1;
        end
      end
      S_DECIDE: begin
        // sidx_r is the insertion point: first segment at or above the block
        res_addr_r <= '0;
        if (ins_full) begin
          res_status_r <= ST_FULL;
          res_len_r    <= '0;
        end else begin
          res_status_r <= ST_OK;
          res_len_r    <= blen_w[31:0];
          pw_en_r      <= 1'b1;
          if (merge_pn) begin
            pw_idx_r  <= SIW'(sidx_r - SCW'(1));
            pw_data_r <= '{base: prev_r.base, len: p_newlen + next_r.len};
            sh_j_r    <= sidx_r;
            sh_lim_r  <= seg_cnt_r - SCW'(1);
          end else if (merge_p) begin
            pw_idx_r  <= SIW'(sidx_r - SCW'(1));
            pw_data_r <= '{base: prev_r.base, len: p_newlen};
          end else if (merge_n) begin
            pw_idx_r  <= sidx_ix;
            pw_data_r <= '{base: real_r, len: next_r.len + blen_r};
          end else begin
            pw_idx_r  <= sidx_ix;
            pw_data_r <= '{base: real_r, len: blen_r};
            sh_up_r   <= 1'b1;
            sh_j_r    <= seg_cnt_r;
            sh_lim_r  <= sidx_r;
          end
        end
      end
      S_SHIFT_WR: sh_j_r <= sh_src;
      S_FIN: begin
        if (fin_go) begin
          out_status_r <= res_status_r;
          out_addr_r   <= res_addr_r;
          out_len_r    <= res_len_r;
          out_used_r   <= used_r;
        end
      end
      default: ;
    endcase
  end

  assign in_chan.ready           = (state_r == S_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.result_address = out_addr_r;
  assign out_chan.block_length   = out_len_r;
  assign out_chan.used_total     = out_used_r;

  // ---------------- assertions ----------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seg_cnt_r <= SCW'(FREE_SEGMENTS))
    else $error("free segment count out of range");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result word raised outside finish");

  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (seg_we && state_r == S_IDLE) |-> cfg_we)
    else $error("segment write while idle without config");

  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_BLK_SCAN)
    else $error("accepted request not started");

  a_blk_write_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    blk_we |-> !valid_r[slot_r])
    else $error("block table write over a live entry");

endmodule
